[src/zero_byte_packer_crc16_defines.svh]
// assertion macros for the zero byte packer
// expects clk_i and rst_ni in the scope of each use
`ifndef ZERO_BYTE_PACKER_CRC16_DEFINES_SVH
`define ZERO_BYTE_PACKER_CRC16_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define ZBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define ZBP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[src/zbp_pkg.sv]
// shared types, constants and the crc step for the zero byte packer
// no dependencies
package zbp_pkg;

  localparam int unsigned GROUP_SIZE  = 8;
  localparam int unsigned GRP_IDX_W   = $clog2(GROUP_SIZE);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_TOP     = 16'h8000;

  // one finished group handed from front to back
  typedef struct packed {
    logic [GROUP_SIZE-1:0][7:0] bytes;
    logic [GROUP_SIZE-1:0]      mask;
    logic                       last;
  } group_t;

  // crc-16 xmodem over one byte, msb first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

[src/zbp_front.sv]
// front end: collects input bytes into groups and builds the nonzero mask
// depends on zbp_pkg
module zbp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  output logic            push_o,
  output zbp_pkg::group_t push_data_o,
  input  logic            full_i
);

  logic [zbp_pkg::GRP_IDX_W-1:0]  pos_q, pos_d;
  logic [zbp_pkg::GROUP_SIZE-1:0] mask_q, mask_d, mask_new;
  logic [7:0]                     store_q [zbp_pkg::GROUP_SIZE];
  logic                           accept;
  logic                           group_done;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // mask including the byte now arriving
  always_comb begin
    mask_new = mask_q;
    if (in_byte_i != 8'h00) begin
      mask_new[pos_q] = 1'b1;
    end
  end

  assign group_done = in_last_i ||
                      (pos_q == zbp_pkg::GRP_IDX_W'(zbp_pkg::GROUP_SIZE - 1));
  assign push_o     = accept && group_done;

  // group handed on, with the arriving byte in place
  always_comb begin
    for (int k = 0; k < zbp_pkg::GROUP_SIZE; k++) begin
      push_data_o.bytes[k] = store_q[k];
    end
    push_data_o.bytes[pos_q] = in_byte_i;
    push_data_o.mask         = mask_new;
    push_data_o.last         = in_last_i;
  end

  // fill position and mask
  always_comb begin
    pos_d  = pos_q;
    mask_d = mask_q;
    if (accept) begin
      if (group_done) begin
        pos_d  = '0;
        mask_d = '0;
      end else begin
        pos_d  = pos_q + 1'b1;
        mask_d = mask_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      mask_q <= '0;
    end else begin
      pos_q  <= pos_d;
      mask_q <= mask_d;
    end
  end

  // byte store, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q[pos_q] <= in_byte_i;
    end
  end

endmodule

[src/zbp_fifo.sv]
// short queue of finished groups between front and back
// depends on zbp_pkg and the assertion macro header
`include "zero_byte_packer_crc16_defines.svh"

module zbp_fifo #(
  parameter int unsigned DEPTH = zbp_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  zbp_pkg::group_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output zbp_pkg::group_t rd_data_o,
  output logic            empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  zbp_pkg::group_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // checks
  `ZBP_ASSERT_NEVER(a_no_overflow, push_i && full_o, "group pushed into full queue")
  `ZBP_ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "group popped from empty queue")
  `ZBP_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

[src/zbp_back.sv]
// back end: emits mask and nonzero bytes of each group, keeps the crc
// depends on zbp_pkg and the assertion macro header
`include "zero_byte_packer_crc16_defines.svh"

module zbp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  zbp_pkg::group_t rd_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [15:0]     out_crc_o,
  output logic            out_mask_o,
  output logic            out_last_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MASK = 3'b010,
    S_DATA = 3'b100
  } back_state_e;

  back_state_e                    state_q, state_d;
  zbp_pkg::group_t                grp_q, grp_d;
  logic [zbp_pkg::GROUP_SIZE-1:0] rem_q, rem_d;
  logic [15:0]                    crc_q, crc_next;
  logic [zbp_pkg::GRP_IDX_W-1:0]  sel;
  logic                           out_free;
  logic                           emit, emit_mask, emit_end;
  logic [7:0]                     emit_byte;
  logic                           valid_q;
  logic [7:0]                     byte_q;
  logic [15:0]                    crc_out_q;
  logic                           mask_q, last_q;

  assign out_free = !valid_q || out_ready_i;

  // lowest remaining nonzero position
  always_comb begin
    sel = '0;
    for (int k = zbp_pkg::GROUP_SIZE - 1; k >= 0; k--) begin
      if (rem_q[k]) begin
        sel = zbp_pkg::GRP_IDX_W'(k);
      end
    end
  end

  // sequencer over one group
  always_comb begin
    state_d   = state_q;
    grp_d     = grp_q;
    rem_d     = rem_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_mask = 1'b0;
    emit_end  = 1'b0;
    emit_byte = '0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          grp_d   = rd_data_i;
          rem_d   = rd_data_i.mask;
          state_d = S_MASK;
        end
      end
      S_MASK: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_mask = 1'b1;
          emit_byte = grp_q.mask;
          if (rem_q == '0) begin
            emit_end = grp_q.last;
            state_d  = S_IDLE;
          end else begin
            state_d  = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = grp_q.bytes[sel];
          rem_d[sel] = 1'b0;
          if (rem_d == '0) begin
            emit_end = grp_q.last;
            state_d  = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign crc_next = zbp_pkg::crc_byte(crc_q, emit_byte);

  // control state and running crc
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rem_q   <= '0;
      crc_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      if (emit) begin
        crc_q <= emit_end ? 16'h0000 : crc_next;
      end
      if (emit) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // group held for emission and output register payload
  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    if (emit) begin
      byte_q    <= emit_byte;
      crc_out_q <= crc_next;
      mask_q    <= emit_mask;
      last_q    <= emit_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_crc_o   = crc_out_q;
  assign out_mask_o  = mask_q;
  assign out_last_o  = last_q;

  // checks
  `ZBP_ASSERT(a_crc_clears, emit && emit_end |=> crc_q == 16'h0000, "crc not cleared after message")
  `ZBP_ASSERT(a_data_nonzero, emit && !emit_mask |-> emit_byte != 8'h00, "zero data byte emitted")
  `ZBP_ASSERT_NEVER(a_pop_busy, pop_o && (state_q != S_IDLE), "group fetched while busy")

endmodule

[src/zero_byte_packer_crc16.sv]
// top level of the zero byte packer with crc-16 xmodem
// depends on zbp_pkg, zbp_front, zbp_fifo and zbp_back
//
// channel   dir  tdata                              tuser    tlast
// s_axis    in   [7:0] data_byte                    -        final_byte
// m_axis    out  [7:0] packed_byte, [23:8] crc_value is_mask end_of_message
//
// the front takes one byte per cycle while the group queue has room.
// for each group the back spends a fetch step, then one output beat for the
// mask and one for each nonzero byte; it fetches a new group only when done.
// the back serializer sets the sustained rate; a stalled output holds the
// back while the front keeps filling the queue. reset clears control only.
module zero_byte_packer_crc16 #(
  parameter int unsigned QUEUE_DEPTH = zbp_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] packed_byte, [23:8] crc_value
  output logic        m_axis_tuser,   // [0] is_mask
  output logic        m_axis_tlast    // end_of_message
);

  zbp_pkg::group_t push_data, rd_data;
  logic            push, full, pop, empty;
  logic [7:0]      out_byte;
  logic [15:0]     out_crc;

  zbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  zbp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .rd_data_o   (rd_data),
    .empty_o     (empty)
  );

  zbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .rd_data_i   (rd_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (out_byte),
    .out_crc_o   (out_crc),
    .out_mask_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_crc, out_byte};

endmodule

[bench/tb_top.sv]
// self-checking bench for zero_byte_packer_crc16: directed and random payload messages
// predicts every packed item in-bench (mask, kept bytes, running crc-16) and checks it
// depends on zbp_pkg and the zero_byte_packer_crc16 top level
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned GRP_BYTES = zbp_pkg::GROUP_SIZE;
  localparam logic [15:0] CRC_GEN   = zbp_pkg::CRC_POLY;
  localparam int unsigned MAX_BEATS = GRP_BYTES + 1;

  // one packed item as seen on the output stream
  typedef struct packed {
    logic [7:0]  packed_byte;
    logic        is_mask;
    logic [15:0] crc_value;
    logic        end_of_message;
  } packed_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tlast;   // final_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] packed_byte, [23:8] crc_value
  logic        m_axis_tuser;   // [0] is_mask
  logic        m_axis_tlast;   // end_of_message

  // bench-side copy of the packer state
  logic [7:0]   grp_bytes [GRP_BYTES];
  logic [7:0]   grp_nz_mask;
  int unsigned  grp_count;
  logic [15:0]  msg_crc;
  packed_item_t packed_q[$];

  // run statistics
  int unsigned n_fail;
  int unsigned n_bytes_in;
  int unsigned n_items_out;
  int unsigned n_messages;
  int unsigned n_full_groups;
  bit          src_gaps_en;
  bit          sink_stall_en;

  zero_byte_packer_crc16 i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("[zero_byte_packer_crc16] ERROR");
    $finish;
  end

  // crc-16 xmodem, one data bit at a time, msb first
  function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CRC_GEN : 16'h0000);
    end
    return r;
  endfunction

  // add one payload byte to the group and queue the packed items it releases
  task automatic predict_packing(input logic [7:0] data, input logic last);
    packed_item_t beats [MAX_BEATS];
    int unsigned  n;
    int unsigned  fill;
    n    = 0;
    fill = grp_count;
    grp_bytes[fill] = data;
    if (data != 8'h00) grp_nz_mask[fill] = 1'b1;
    fill++;
    if (fill < GRP_BYTES && !last) begin
      grp_count = fill;
      return;
    end
    if (fill == GRP_BYTES) n_full_groups++;
    // mask first, then the kept bytes in order
    msg_crc  = crc16_next(msg_crc, grp_nz_mask);
    beats[0] = '{packed_byte: grp_nz_mask, is_mask: 1'b1, crc_value: msg_crc,
                 end_of_message: 1'b0};
    n = 1;
    for (int unsigned k = 0; k < fill; k++) begin
      if (grp_nz_mask[k]) begin
        msg_crc  = crc16_next(msg_crc, grp_bytes[k]);
        beats[n] = '{packed_byte: grp_bytes[k], is_mask: 1'b0, crc_value: msg_crc,
                     end_of_message: 1'b0};
        n++;
      end
    end
    if (last) begin
      beats[n-1].end_of_message = 1'b1;
      msg_crc = 16'h0000;
      n_messages++;
    end
    for (int unsigned k = 0; k < n; k++) packed_q.push_back(beats[k]);
    grp_nz_mask = 8'h00;
    grp_count   = 0;
  endtask

  // drive one payload item, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] data, input logic last);
    int unsigned gap;
    if (src_gaps_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_packing(data, last);
    n_bytes_in++;
  endtask

  // random payload byte, zero with the given percentage
  function automatic logic [7:0] rand_payload(int unsigned zero_pct);
    if ($urandom_range(0, 99) < zero_pct) return 8'h00;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_message(input int unsigned len, input int unsigned zero_pct);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(rand_payload(zero_pct), i == len - 1);
    end
  endtask

  // sink backpressure in random bursts
  initial begin
    int unsigned burst;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_stall_en && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 18);
        m_axis_tready <= 1'b0;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // compare every accepted output item with the oldest prediction
  always @(posedge clk_i) begin
    packed_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_items_out++;
      if (packed_q.size() == 0) begin
        $error("unexpected item: packed_byte %h is_mask %b crc %h eom %b",
               m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[23:8], m_axis_tlast);
        n_fail++;
      end else begin
        want = packed_q.pop_front();
        if (m_axis_tdata[7:0] !== want.packed_byte) begin
          $error("packed_byte: expected %h, got %h", want.packed_byte, m_axis_tdata[7:0]);
          n_fail++;
        end
        if (m_axis_tuser !== want.is_mask) begin
          $error("is_mask: expected %b, got %b", want.is_mask, m_axis_tuser);
          n_fail++;
        end
        if (m_axis_tdata[23:8] !== want.crc_value) begin
          $error("crc_value: expected %h, got %h", want.crc_value, m_axis_tdata[23:8]);
          n_fail++;
        end
        if (m_axis_tlast !== want.end_of_message) begin
          $error("end_of_message: expected %b, got %b", want.end_of_message, m_axis_tlast);
          n_fail++;
        end
      end
    end
  end

  // corner cases: one-byte messages, all-zero and all-nonzero groups,
  // final byte landing on a full group, short final group after a full one
  task automatic test_directed();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h33, 1'b1);
    for (int i = 0; i < 8; i++) send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // random messages of mixed length and zero density, idling on both sides
  task automatic test_random_messages();
    int unsigned len;
    int unsigned zpct;
    src_gaps_en   = 1'b1;
    sink_stall_en = 1'b1;
    while (n_bytes_in < 100) begin
      case ($urandom_range(0, 5))
        0:       len = GRP_BYTES;
        1:       len = 2 * GRP_BYTES;
        2:       len = $urandom_range(1, 3);
        default: len = $urandom_range(1, 24);
      endcase
      case ($urandom_range(0, 3))
        0:       zpct = 0;
        1:       zpct = 100;
        default: zpct = $urandom_range(10, 80);
      endcase
      send_message(len, zpct);
    end
  endtask

  // back-to-back items with the sink always ready
  task automatic test_full_rate();
    src_gaps_en   = 1'b0;
    sink_stall_en = 1'b0;
    send_message(GRP_BYTES, 0);
    send_message(13, 40);
    send_message(GRP_BYTES + 1, 0);
    send_message(5, 100);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    grp_nz_mask   = 8'h00;
    grp_count     = 0;
    msg_crc       = 16'h0000;
    n_fail        = 0;
    n_bytes_in    = 0;
    n_items_out   = 0;
    n_messages    = 0;
    n_full_groups = 0;
    src_gaps_en   = 1'b0;
    sink_stall_en = 1'b0;
    foreach (grp_bytes[i]) grp_bytes[i] = 8'h00;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_messages();
    test_full_rate();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (packed_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("covered %0d payload bytes in %0d messages (%0d full groups), %0d packed items",
             n_bytes_in, n_messages, n_full_groups, n_items_out);
    if (n_fail == 0) begin
      $display("[zero_byte_packer_crc16] OK");
    end else begin
      $display("[zero_byte_packer_crc16] ERROR");
    end
    $finish;
  end

endmodule
